// ----- sv/sfp_pkg.sv -----
`default_nettype none
package sfp_pkg;

	typedef enum logic [3:0] {
		PH_MAGIC   = 4'd0,
		PH_TICK    = 4'd1,
		PH_BASE    = 4'd2,
		PH_HASH    = 4'd3,
		PH_COUNT   = 4'd4,
		PH_ID      = 4'd5,
		PH_MASK    = 4'd6,
		PH_PLEN    = 4'd7,
		PH_PAYLOAD = 4'd8,
		PH_DONE    = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_ENTITY  = 3'd1,
		KIND_PAYLOAD = 3'd2,
		KIND_SUCCESS = 3'd3,
		KIND_FAILURE = 3'd4
	} kind_t;

	localparam logic [1:0] FAIL_NONE  = 2'd0;
	localparam logic [1:0] FAIL_MAGIC = 2'd1;
	localparam logic [1:0] FAIL_SHORT = 2'd2;

	// one output record
	typedef struct packed {
		kind_t       kind;
		logic [31:0] tick;
		logic [31:0] baseline;
		logic [63:0] hash;
		logic [31:0] total;
		logic [63:0] key;
		logic [31:0] mask;
		logic [15:0] plen;
		logic [7:0]  value;
		logic [1:0]  fail;
		logic        last;
	} rec_t;

	// up to two records caused by one item
	typedef struct packed {
		logic [1:0] count;
		rec_t       r0;
		rec_t       r1;
	} bundle_t;

	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	function automatic logic [2:0] field_len(input phase_t ph);
		logic [2:0] n;
		begin
			unique case (ph)
				PH_HASH, PH_ID: n = 3'd0; // eight bytes wrap to zero
				PH_PLEN:        n = 3'd2;
				default:        n = 3'd4;
			endcase
			return n;
		end
	endfunction

	function automatic rec_t blank_rec(input kind_t k);
		rec_t r;
		begin
			r = '0;
			r.kind = k;
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ----- sv/snapshot_frame_parser_core.sv -----
// output: a byte's records are registered in the queue when it is accepted and go out from its head
// throughput: one byte per cycle while the queue is not full; a byte that yields two
//   records sends them out one after the other, absorbed by a four-entry queue of record pairs
// reset: arst_n asynchronous active low clears parse state, magic and queue
`default_nettype none
module snapshot_frame_parser_core import sfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_buffer,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       record_kind,
	output logic [31:0]      tick_number,
	output logic [31:0]      baseline_number,
	output logic [63:0]      state_hash,
	output logic [31:0]      entry_total,
	output logic [63:0]      entity_key,
	output logic [31:0]      changed_mask,
	output logic [15:0]      payload_length,
	output logic [7:0]       payload_value,
	output logic [1:0]       failure_code,
	output logic             last_of_run
);
	logic [31:0] magic_q;
	bundle_t     bundle;
	logic        full, take, push;
	rec_t        rec;

	// expected magic register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) magic_q <= '0;
		else if (cfg_we) magic_q <= cfg_wdata;
	end

	// front classifies a byte whenever the queue has room
	assign in_stall = full;
	assign take = in_valid && !full;
	// bytes that cause no record leave nothing in the queue
	assign push = take && (bundle.count != 2'd0);

	sfp_front u_front (
		.clk(clk), .arst_n(arst_n), .magic(magic_q), .take(take),
		.data_byte(data_byte), .end_of_buffer(end_of_buffer), .bundle(bundle)
	);

	sfp_back u_back (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(bundle),
		.full(full), .out_valid(out_valid), .out_rec(rec), .out_stall(out_stall)
	);

	assign record_kind     = rec.kind;
	assign tick_number     = rec.tick;
	assign baseline_number = rec.baseline;
	assign state_hash      = rec.hash;
	assign entry_total     = rec.total;
	assign entity_key      = rec.key;
	assign changed_mask    = rec.mask;
	assign payload_length  = rec.plen;
	assign payload_value   = rec.value;
	assign failure_code    = rec.fail;
	assign last_of_run     = rec.last;
endmodule
`default_nettype wire

// ----- sv/sfp_front.sv -----
`default_nettype none
module sfp_front import sfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] magic,
	input  wire logic        take,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_buffer,
	output bundle_t          bundle
);
	phase_t      phase_q;
	logic [2:0]  pos_q;
	logic [63:0] shift_q;
	logic [31:0] tick_q, base_q, left_q, mask_q;
	logic [63:0] hash_q, key_q;
	logic [15:0] pleft_q;

	phase_t      phase_n, phase_d;
	logic [2:0]  pos_inc, pos_d;
	logic [63:0] shift_d, v;
	logic [31:0] left_dec, left_d;
	logic [15:0] pleft_dec, pleft_d;
	logic        done_field;
	rec_t        r0, r1;
	logic [1:0]  n;

	assign v = shift_q | ({56'd0, data_byte} << {pos_q, 3'b000});
	assign pos_inc = pos_q + 3'd1;
	assign left_dec = left_q - 32'd1;
	assign pleft_dec = pleft_q - 16'd1;
	assign done_field = (phase_q < PH_PAYLOAD) && (pos_inc == field_len(phase_q));

	// next state
	always_comb begin
		phase_n = phase_q;
		pos_d = pos_q;
		shift_d = shift_q;
		left_d = left_q;
		pleft_d = pleft_q;
		if (phase_q < PH_PAYLOAD) begin
			shift_d = v;
			pos_d = pos_inc;
			if (done_field) begin
				shift_d = '0;
				pos_d = '0;
				unique case (phase_q)
					PH_MAGIC: phase_n = (v[31:0] != magic) ? PH_DONE : PH_TICK;
					PH_TICK:  phase_n = PH_BASE;
					PH_BASE:  phase_n = PH_HASH;
					PH_HASH:  phase_n = PH_COUNT;
					PH_COUNT: begin
						left_d = v[31:0];
						phase_n = (v[31:0] == '0) ? PH_DONE : PH_ID;
					end
					PH_ID:   phase_n = PH_MASK;
					PH_MASK: phase_n = PH_PLEN;
					default: begin
						pleft_d = v[15:0];
						if (v[15:0] == '0) begin
							left_d = left_dec;
							phase_n = (left_dec == '0) ? PH_DONE : PH_ID;
						end else begin
							phase_n = PH_PAYLOAD;
						end
					end
				endcase
			end
		end else if (phase_q == PH_PAYLOAD) begin
			pleft_d = pleft_dec;
			if (pleft_dec == '0) begin
				left_d = left_dec;
				phase_n = (left_dec == '0) ? PH_DONE : PH_ID;
			end
		end
		phase_d = phase_n;
		if (end_of_buffer) begin
			phase_d = PH_MAGIC;
			pos_d = '0;
			shift_d = '0;
		end
	end

	// records caused by the current byte
	always_comb begin
		r0 = blank_rec(KIND_HEADER);
		r1 = blank_rec(KIND_HEADER);
		n = 2'd0;
		if (done_field) begin
			unique case (phase_q)
				PH_MAGIC: begin
					if (v[31:0] != magic) begin
						r0 = blank_rec(KIND_FAILURE);
						r0.fail = FAIL_MAGIC;
						n = 2'd1;
					end
				end
				PH_COUNT: begin
					r0.tick = tick_q;
					r0.baseline = base_q;
					r0.hash = hash_q;
					r0.total = v[31:0];
					n = 2'd1;
					if (v[31:0] == '0) begin
						r1 = blank_rec(KIND_SUCCESS);
						n = 2'd2;
					end
				end
				PH_PLEN: begin
					r0 = blank_rec(KIND_ENTITY);
					r0.key = key_q;
					r0.mask = mask_q;
					r0.plen = v[15:0];
					n = 2'd1;
					if (v[15:0] == '0 && left_dec == '0) begin
						r1 = blank_rec(KIND_SUCCESS);
						n = 2'd2;
					end
				end
				default: ;
			endcase
		end else if (phase_q == PH_PAYLOAD) begin
			r0 = blank_rec(KIND_PAYLOAD);
			r0.value = data_byte;
			n = 2'd1;
			if (pleft_dec == '0 && left_dec == '0) begin
				r1 = blank_rec(KIND_SUCCESS);
				n = 2'd2;
			end
		end
		// buffer ended with the frame unfinished
		if (end_of_buffer && phase_n < PH_DONE) begin
			if (n == 2'd0) begin
				r0 = blank_rec(KIND_FAILURE);
				r0.fail = FAIL_SHORT;
			end else begin
				r1 = blank_rec(KIND_FAILURE);
				r1.fail = FAIL_SHORT;
			end
			n = n + 2'd1;
		end
		if (n == 2'd1) r0.last = 1'b1;
		if (n == 2'd2) r1.last = 1'b1;
		bundle.count = n;
		bundle.r0 = r0;
		bundle.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			pos_q <= '0;
			shift_q <= '0;
			tick_q <= '0;
			base_q <= '0;
			hash_q <= '0;
			left_q <= '0;
			key_q <= '0;
			mask_q <= '0;
			pleft_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			shift_q <= shift_d;
			left_q <= left_d;
			pleft_q <= pleft_d;
			if (done_field) begin
				unique case (phase_q)
					PH_TICK: tick_q <= v[31:0];
					PH_BASE: base_q <= v[31:0];
					PH_HASH: hash_q <= v;
					PH_ID:   key_q <= v;
					PH_MASK: mask_q <= v[31:0];
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/sfp_back.sv -----
`default_nettype none
module sfp_back import sfp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t push_data,
	output logic         full,
	output logic         out_valid,
	output rec_t         out_rec,
	input  wire logic    out_stall
);
	bundle_t      mem [QDEPTH];
	logic [QAW:0] wr_q, rd_q;
	logic         sub_q;
	logic         empty, pop;
	bundle_t      head;

	assign empty = (wr_q == rd_q);
	assign full = (wr_q[QAW] != rd_q[QAW]) && (wr_q[QAW-1:0] == rd_q[QAW-1:0]);
	assign head = mem[rd_q[QAW-1:0]];
	assign out_valid = !empty;
	assign out_rec = sub_q ? head.r1 : head.r0;
	// bundle leaves after its last record goes out
	assign pop = out_valid && !out_stall && (sub_q || head.count == 2'd1);

	always_ff @(posedge clk) begin
		if (push) mem[wr_q[QAW-1:0]] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			sub_q <= 1'b0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) begin
				rd_q <= rd_q + 1'b1;
				sub_q <= 1'b0;
			end else if (out_valid && !out_stall) begin
				sub_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- tb/snapshot_frame_parser_core_test.sv -----
`default_nettype none
module snapshot_frame_parser_core_test import sfp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        end_of_buffer = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  record_kind;
	logic [31:0] tick_number, baseline_number, entry_total, changed_mask;
	logic [63:0] state_hash, entity_key;
	logic [15:0] payload_length;
	logic [7:0]  payload_value;
	logic [1:0]  failure_code;
	logic        last_of_run;

	snapshot_frame_parser_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.end_of_buffer(end_of_buffer), .out_valid(out_valid), .out_stall(out_stall),
		.record_kind(record_kind), .tick_number(tick_number),
		.baseline_number(baseline_number), .state_hash(state_hash),
		.entry_total(entry_total), .entity_key(entity_key),
		.changed_mask(changed_mask), .payload_length(payload_length),
		.payload_value(payload_value), .failure_code(failure_code),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state, mirrors the parser
	logic [31:0] magic_word;
	phase_t      phase;
	logic [2:0]  pos;
	logic [63:0] shifter;
	logic [31:0] tick_q, base_q, left_entries, mask_q;
	logic [63:0] hash_q, key_q;
	logic [15:0] left_payload;

	rec_t record_queue[$];
	int   mismatches = 0;
	int   sent_bytes = 0;
	int   burst_left = 0;

	task automatic reset_parse();
		phase = PH_MAGIC;
		pos = '0;
		shifter = '0;
	endtask

	task automatic push_rec(input rec_t r);
		record_queue = {record_queue, r};
	endtask

	// entry done: either success or next id
	task automatic close_entry(inout rec_t rs[$]);
		left_entries = left_entries - 1;
		if (left_entries == 0) begin
			rs = {rs, blank_rec(KIND_SUCCESS)};
			phase = PH_DONE;
		end else begin
			phase = PH_ID;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic eob);
		rec_t rs[$];
		rec_t r;
		logic [2:0] need;
		logic [63:0] v;
		if (phase < PH_PAYLOAD) begin
			shifter = shifter | (64'(b) << (8 * pos));
			pos = pos + 3'd1;
			case (phase)
				PH_HASH, PH_ID: need = 3'd0;
				PH_PLEN:        need = 3'd2;
				default:        need = 3'd4;
			endcase
			if (pos == need) begin
				v = shifter;
				shifter = '0;
				pos = '0;
				case (phase)
					PH_MAGIC: begin
						if (v[31:0] != magic_word) begin
							r = blank_rec(KIND_FAILURE);
							r.fail = FAIL_MAGIC;
							rs = {rs, r};
							phase = PH_DONE;
						end else phase = PH_TICK;
					end
					PH_TICK: begin tick_q = v[31:0]; phase = PH_BASE; end
					PH_BASE: begin base_q = v[31:0]; phase = PH_HASH; end
					PH_HASH: begin hash_q = v; phase = PH_COUNT; end
					PH_COUNT: begin
						left_entries = v[31:0];
						r = blank_rec(KIND_HEADER);
						r.tick = tick_q;
						r.baseline = base_q;
						r.hash = hash_q;
						r.total = left_entries;
						rs = {rs, r};
						if (left_entries == 0) begin
							rs = {rs, blank_rec(KIND_SUCCESS)};
							phase = PH_DONE;
						end else phase = PH_ID;
					end
					PH_ID: begin key_q = v; phase = PH_MASK; end
					PH_MASK: begin mask_q = v[31:0]; phase = PH_PLEN; end
					default: begin
						left_payload = v[15:0];
						r = blank_rec(KIND_ENTITY);
						r.key = key_q;
						r.mask = mask_q;
						r.plen = left_payload;
						rs = {rs, r};
						if (left_payload == 0) close_entry(rs);
						else phase = PH_PAYLOAD;
					end
				endcase
			end
		end else if (phase == PH_PAYLOAD) begin
			r = blank_rec(KIND_PAYLOAD);
			r.value = b;
			rs = {rs, r};
			left_payload = left_payload - 16'd1;
			if (left_payload == 0) close_entry(rs);
		end
		if (eob) begin
			if (phase < PH_DONE) begin
				r = blank_rec(KIND_FAILURE);
				r.fail = FAIL_SHORT;
				rs = {rs, r};
			end
			reset_parse();
		end
		if (rs.size() > 0) rs[rs.size() - 1].last = 1'b1;
		foreach (rs[i]) push_rec(rs[i]);
	endtask

	// one item through the handshake, with bursty gaps
	task automatic send_byte(input logic [7:0] b, input logic eob);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		do @(posedge clk); while (in_stall);
		predict_byte(b, eob);
		sent_bytes++;
	endtask

	// full frame with given content; cut_at >= 0 ends the buffer early
	task automatic send_frame(input logic [31:0] m, input int n_ent, input int max_len,
			input int cut_at, input logic trailing);
		logic [7:0] bytes[$];
		logic [63:0] w;
		int len;
		for (int i = 0; i < 4; i++) bytes = {bytes, m[8*i +: 8]};
		// tick and baseline
		w = {$urandom, $urandom};
		for (int i = 0; i < 8; i++) bytes = {bytes, w[8*i +: 8]};
		// hash
		w = {$urandom, $urandom};
		for (int i = 0; i < 8; i++) bytes = {bytes, w[8*i +: 8]};
		for (int i = 0; i < 4; i++) bytes = {bytes, 8'(n_ent >> (8 * i))};
		for (int e = 0; e < n_ent; e++) begin
			for (int i = 0; i < 12; i++) bytes = {bytes, 8'($urandom)};
			len = $urandom_range(0, max_len);
			bytes = {bytes, 8'(len)};
			bytes = {bytes, 8'(len >> 8)};
			for (int i = 0; i < len; i++) bytes = {bytes, 8'($urandom)};
		end
		if (trailing) repeat ($urandom_range(1, 4)) bytes = {bytes, 8'($urandom)};
		if (cut_at >= 0 && cut_at < bytes.size()) bytes = bytes[0:cut_at];
		foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (record_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_magic(input logic [31:0] m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		magic_word = m;
	endtask

	// receiver stall pattern: free flow half the time, else stall at random with a chance of one in four
	always @(posedge clk) begin
		if (($urandom_range(0, 199) < 100)) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	// record checker
	always @(posedge clk) begin
		rec_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind: kind_t'(record_kind), tick: tick_number,
				baseline: baseline_number, hash: state_hash, total: entry_total,
				key: entity_key, mask: changed_mask, plen: payload_length,
				value: payload_value, fail: failure_code, last: last_of_run};
			if (record_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected record %h", got);
			end else begin
				want = record_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("record mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	// directed: bad magic, empty frame, zero-length and max-value fields
	task automatic test_directed();
		write_magic(32'hFFFF_FFFF);
		send_frame(32'hFFFF_FFFF, 0, 0, -1, 1'b1);
		send_frame(32'h0000_0000, 1, 0, -1, 1'b1);
		send_frame(32'hFFFF_FFFF, 2, 3, -1, 1'b0);
		send_frame(32'hFFFF_FFFE, 0, 0, 2, 1'b0);
		wait_drained();
	endtask

	// well-formed frames with random content under several magics
	task automatic test_frames();
		logic [31:0] m;
		for (int k = 0; k < 3; k++) begin
			m = (k == 0) ? 32'h0 : $urandom;
			write_magic(m);
			repeat (8) send_frame(m, $urandom_range(0, 3), 6, -1, $urandom_range(0, 1));
			wait_drained();
		end
	endtask

	// truncated buffers, wrong magic, raw noise; fills up the item budget
	task automatic test_broken();
		write_magic($urandom);
		for (int k = 0; k < 10 || sent_bytes < 1950; k++) begin
			case ($urandom_range(0, 2))
				0: send_frame(magic_word, $urandom_range(1, 3), 5, $urandom_range(0, 60), 1'b0);
				1: send_frame(magic_word ^ (32'd1 << $urandom_range(0, 31)), 1, 2, -1, 1'b0);
				default: repeat ($urandom_range(1, 10))
					send_byte(8'($urandom), $urandom_range(0, 5) == 0);
			endcase
		end
		send_byte(8'h00, 1'b1);
		wait_drained();
	endtask

	// a larger payload, whose length may have its high byte set
	task automatic test_long_payload();
		write_magic(32'hA5A5_5A5A);
		send_frame(32'hA5A5_5A5A, 1, 300, -1, 1'b0);
		wait_drained();
	endtask

	initial begin
		magic_word = '0;
		tick_q = '0; base_q = '0; hash_q = '0; left_entries = '0;
		key_q = '0; mask_q = '0; left_payload = '0;
		reset_parse();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_payload();
		test_frames();
		test_broken();
		wait_drained();
		if (mismatches == 0 && record_queue.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/sfp_pkg.sv
sv/sfp_front.sv
sv/sfp_back.sv
sv/snapshot_frame_parser_core.sv
tb/snapshot_frame_parser_core_test.sv
